FILE: rtl/pidv_pkg.sv
// Shared types and constants for the four-wheel PID velocity loop.
// No dependencies.
package pidv_pkg;

    localparam int MOTORS_DEF = 4;

    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int TGT_W   = 16;
    localparam int ENC_W   = 32;
    localparam int INTEG_W = 48;
    localparam int DRV_W   = 16;
    localparam int CFG_IW  = 3;

    localparam logic [GAIN_W-1:0] KP_RST  = 16'd20;
    localparam logic [GAIN_W-1:0] KD_RST  = 16'd12;
    localparam logic [GAIN_W-1:0] KI_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] KO_RST  = 16'd50;
    localparam logic [LIM_W-1:0]  LIM_RST = 15'd255;

    typedef enum logic [CFG_IW-1:0] {
        REG_KP  = 3'd0,
        REG_KD  = 3'd1,
        REG_KI  = 3'd2,
        REG_KO  = 3'd3,
        REG_LIM = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_RD,
        S_CALC,
        S_MP,
        S_MD,
        S_SUM,
        S_ABS,
        S_CMP,
        S_DIV,
        S_WR,
        S_OUT
    } t_state;

    // one motor's controller state as held in the state RAM
    typedef struct packed {
        logic        [ENC_W-1:0]   last_count;
        logic signed [ENC_W-1:0]   last_speed;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DRV_W-1:0]   drive;
    } t_ent;

    localparam int ENT_W = $bits(t_ent);

endpackage

FILE: rtl/pidv_in_if.sv
// Input channel of the PID velocity loop: one control tick per transaction.
// Depends on pidv_pkg.
interface pidv_in_if #(
    parameter int MOTORS = pidv_pkg::MOTORS_DEF
);
    logic valid;
    logic ready;
    logic moving;
    logic reset_request;
    logic signed [MOTORS-1:0][pidv_pkg::TGT_W-1:0] target;
    logic signed [MOTORS-1:0][pidv_pkg::ENC_W-1:0] encoder;

    modport source (output valid, moving, reset_request, target, encoder, input ready);
    modport sink   (input valid, moving, reset_request, target, encoder, output ready);
endinterface

interface pidv_out_if #(
    parameter int MOTORS = pidv_pkg::MOTORS_DEF
);
    logic valid;
    logic ready;
    logic signed [MOTORS-1:0][pidv_pkg::DRV_W-1:0] drive;
    logic drive_valid;

    modport source (output valid, drive, drive_valid, input ready);
    modport sink   (input valid, drive, drive_valid, output ready);
endinterface

FILE: rtl/pidv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pidv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/four_wheel_pid_velocity_loop.sv
// Four-wheel PID velocity loop with anti-windup; state held in one RAM entry per motor.
// Per motor on a moving tick: read, two gain multiplies, compare against limit*ko,
// then a 15-step radix-2 divide unless clamped; stop/reset ticks clear each motor's
// state in turn, or go straight to the output when no clear is needed.
// One tick at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset: gains to defaults, all motor state reads as zero.
module four_wheel_pid_velocity_loop #(
    parameter int MOTORS = pidv_pkg::MOTORS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pidv_in_if.sink                    i_in,
    pidv_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [pidv_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [pidv_pkg::GAIN_W-1:0] i_cfg_data
);
    import pidv_pkg::*;

    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // configuration
    logic [GAIN_W-1:0] r_kp, r_kd, r_ki, r_ko;
    logic [LIM_W-1:0]  r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= KP_RST;
            r_kd  <= KD_RST;
            r_ki  <= KI_RST;
            r_ko  <= KO_RST;
            r_lim <= LIM_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_KP:  r_kp  <= i_cfg_data;
                REG_KD:  r_kd  <= i_cfg_data;
                REG_KI:  r_ki  <= i_cfg_data;
                REG_KO:  r_ko  <= i_cfg_data;
                REG_LIM: r_lim <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [GAIN_W-1:0] w_div;
    assign w_div = (r_ko == '0) ? GAIN_W'(1) : r_ko;

    // control and datapath registers
    t_state r_state, n_state;
    logic [MW-1:0] r_m;
    logic [MOTORS-1:0] r_vld, r_snz;
    logic r_mov, r_rst;
    logic signed [MOTORS-1:0][TGT_W-1:0] r_tgt;
    logic signed [MOTORS-1:0][ENC_W-1:0] r_enc;
    logic signed [MOTORS-1:0][DRV_W-1:0] r_drv;
    logic r_dv;

    logic signed [ENC_W-1:0]   r_speed;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ENC_W:0]     r_err, r_dspd;
    logic        [30:0]        r_limdiv;
    logic signed [49:0]        r_p, r_d, r_kie;
    logic signed [51:0]        r_sum;
    logic                      r_neg, r_clamp;
    logic        [50:0]        r_abs;
    logic signed [INTEG_W-1:0] r_ni;
    logic        [30:0]        r_rem;
    logic        [LIM_W-1:0]   r_q;
    logic        [3:0]         r_cnt;

    logic r_ov;
    logic signed [MOTORS-1:0][DRV_W-1:0] r_odrv;
    logic r_odv;

    // state RAM
    logic [ENT_W-1:0] w_rdata, w_wdata;
    logic             w_we;
    t_ent             w_ent, w_went;

    pidv_ram #(.WIDTH(ENT_W), .DEPTH(MOTORS), .AW(MW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_m),
        .i_wdata (w_wdata),
        .i_raddr (r_m),
        .o_rdata (w_rdata)
    );

    // entries never written read as zero
    assign w_ent = r_vld[r_m] ? t_ent'(w_rdata) : '0;

    logic w_last, w_acc, w_stop, w_load;
    assign w_last = (r_m == MW'(MOTORS - 1));
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_stop = i_in.reset_request || !i_in.moving;
    assign w_load = (r_state == S_OUT) && (!r_ov || o_out.ready);

    // speed and error terms for the motor being read
    logic        [ENC_W-1:0] w_spd;
    logic signed [ENC_W:0]   w_err, w_dspd;
    assign w_spd  = r_enc[r_m] - w_ent.last_count;
    assign w_err  = $signed({{(ENC_W + 1 - TGT_W){r_tgt[r_m][TGT_W-1]}}, r_tgt[r_m]})
                  - $signed({w_spd[ENC_W-1], w_spd});
    assign w_dspd = $signed({w_spd[ENC_W-1], w_spd})
                  - $signed({w_ent.last_speed[ENC_W-1], w_ent.last_speed});

    // integral update with 48-bit saturation
    logic signed [50:0] w_ni;
    assign w_ni = $signed({{3{r_integ[INTEG_W-1]}}, r_integ}) + $signed({r_kie[49], r_kie});

    // one restoring divide step
    logic [30:0] w_dsh;
    logic        w_ge;
    assign w_dsh = 31'({15'd0, w_div} << r_cnt);
    assign w_ge  = (r_rem >= w_dsh);

    logic signed [DRV_W-1:0] w_drive;
    always_comb begin
        if (r_clamp) begin
            w_drive = r_neg ? -$signed({1'b0, r_lim}) : $signed({1'b0, r_lim});
        end else begin
            w_drive = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_stop) begin
                        n_state = (i_in.reset_request || (r_snz != '0)) ? S_CLR : S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_CLR:   n_state = w_last ? S_OUT : S_CLR;
            S_RD:    n_state = S_CALC;
            S_CALC:  n_state = S_MP;
            S_MP:    n_state = S_MD;
            S_MD:    n_state = S_SUM;
            S_SUM:   n_state = S_ABS;
            S_ABS:   n_state = S_CMP;
            S_CMP:   n_state = ({20'd0, r_limdiv} <= r_abs) ? S_WR : S_DIV;
            S_DIV:   n_state = (r_cnt == '0) ? S_WR : S_DIV;
            S_WR:    n_state = w_last ? S_OUT : S_RD;
            S_OUT:   n_state = w_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: RAM write and handshake
    always_comb begin
        w_we   = 1'b0;
        w_went = '0;
        case (r_state)
            S_CLR: begin
                w_we              = 1'b1;
                w_went.last_count = r_enc[r_m];
            end
            S_WR: begin
                w_we              = 1'b1;
                w_went.last_count = r_enc[r_m];
                w_went.last_speed = r_speed;
                w_went.integ      = r_clamp ? r_integ : r_ni;
                w_went.drive      = w_drive;
            end
            default: ;
        endcase
    end
    assign w_wdata    = w_went;
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_m     <= '0;
            r_vld   <= '0;
            r_snz   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_m <= '0;
            end else if ((r_state == S_CLR || r_state == S_WR) && !w_last) begin
                r_m <= r_m + MW'(1);
            end
            if (w_we) begin
                r_vld[r_m] <= 1'b1;
                r_snz[r_m] <= (r_state == S_WR) && (r_speed != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mov <= i_in.moving;
            r_rst <= i_in.reset_request;
            r_tgt <= i_in.target;
            r_enc <= i_in.encoder;
            r_drv <= '0;
            r_dv  <= !w_stop;
        end
        case (r_state)
            S_CALC: begin
                r_speed  <= w_spd;
                r_integ  <= w_ent.integ;
                r_err    <= w_err;
                r_dspd   <= w_dspd;
                r_limdiv <= r_lim * w_div;
            end
            S_MP:  r_p <= $signed({1'b0, r_kp}) * r_err;
            S_MD:  r_d <= $signed({1'b0, r_kd}) * r_dspd;
            S_SUM: begin
                r_sum <= $signed({{2{r_p[49]}}, r_p}) - $signed({{2{r_d[49]}}, r_d})
                       + $signed({{4{r_integ[INTEG_W-1]}}, r_integ});
            end
            S_ABS: begin
                r_neg <= r_sum[51];
                r_abs <= r_sum[51] ? 51'(-r_sum) : r_sum[50:0];
                r_kie <= $signed({1'b0, r_ki}) * r_err;
            end
            S_CMP: begin
                r_clamp <= ({20'd0, r_limdiv} <= r_abs);
                if (w_ni[50:47] != {4{w_ni[50]}}) begin
                    r_ni <= w_ni[50] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                     : {1'b0, {(INTEG_W - 1){1'b1}}};
                end else begin
                    r_ni <= w_ni[INTEG_W-1:0];
                end
                r_rem <= r_abs[30:0];
                r_q   <= '0;
                r_cnt <= 4'(LIM_W - 1);
            end
            S_DIV: begin
                if (w_ge) begin
                    r_rem        <= r_rem - w_dsh;
                    r_q[r_cnt]   <= 1'b1;
                end
                r_cnt <= r_cnt - 4'd1;
            end
            S_WR: r_drv[r_m] <= w_drive;
            default: ;
        endcase
        if (w_load) begin
            r_odrv <= r_drv;
            r_odv  <= r_dv;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.drive       = r_odrv;
    assign o_out.drive_valid = r_odv;

    // unclamped quotient stays below the limit
    a_q_below_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && !r_clamp) |-> (r_q < r_lim))
        else $error("unclamped drive reached limit");

    // stop ticks give zero drives
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.drive_valid) |-> (o_out.drive == '0))
        else $error("nonzero drive on stop tick");

    // remainder bounded by the current divisor weight
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < ({1'b0, w_dsh} << 1)))
        else $error("divide remainder out of range");

    // a stop tick never runs the control law datapath
    a_stop_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_mov && !r_rst))
        else $error("control law on stop tick");
endmodule

FILE: bench/tb_four_wheel_pid_velocity_loop.sv
// Self-checking bench for the four-wheel PID velocity loop.
// Depends on pidv_pkg, pidv_in_if / pidv_out_if and four_wheel_pid_velocity_loop.
`timescale 1ns / 1ps

module tb_four_wheel_pid_velocity_loop;
    import pidv_pkg::*;

    localparam int NM = MOTORS_DEF;
    localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    typedef struct {
        bit                 mov;
        bit                 rqr;
        logic signed [15:0] tgt [NM];
        logic [31:0]        enc [NM];
    } tick_t;

    typedef struct {
        logic signed [15:0] drv [NM];
        bit                 dv;
    } drive_t;

    typedef struct {
        bit        is_cfg;
        t_reg      reg_idx;
        int unsigned data;
        tick_t     tk;
        bit        typed;
        bit        typed_dv;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [GAIN_W-1:0] i_cfg_data = '0;

    pidv_in_if  #(.MOTORS(NM)) in_if ();
    pidv_out_if #(.MOTORS(NM)) out_if ();

    four_wheel_pid_velocity_loop #(.MOTORS(NM)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // controller mirror
    longint      g_kp, g_kd, g_ki, g_ko, g_lim;
    logic [31:0] m_count [NM];
    longint      m_speed [NM];
    longint      m_integ [NM];

    drive_t expected_drives [$];
    row_t   stim_table [$];
    int     n_sent = 0;
    int     n_rx = 0;
    bit     failed = 0;
    logic [31:0] cur_enc [NM];

    function automatic drive_t pid_tick(tick_t t);
        drive_t r;
        bit clr;
        longint tgt, spd, err, dsp, dv, sum, drv, ni;
        logic signed [31:0] d32;
        r.dv = 0;
        for (int i = 0; i < NM; i++) r.drv[i] = '0;
        if (t.rqr || !t.mov) begin
            clr = t.rqr;
            for (int i = 0; i < NM; i++) if (m_speed[i] != 0) clr = 1;
            if (clr) begin
                for (int i = 0; i < NM; i++) begin
                    m_count[i] = t.enc[i];
                    m_speed[i] = 0;
                    m_integ[i] = 0;
                end
            end
            return r;
        end
        r.dv = 1;
        for (int i = 0; i < NM; i++) begin
            tgt = t.tgt[i];
            d32 = t.enc[i] - m_count[i];
            spd = d32;
            err = tgt - spd;
            dsp = spd - m_speed[i];
            dv  = (g_ko == 0) ? 1 : g_ko;
            sum = g_kp * err - g_kd * dsp + m_integ[i];
            drv = sum / dv;
            m_count[i] = t.enc[i];
            if (drv >= g_lim) begin
                drv = g_lim;
            end else if (drv <= -g_lim) begin
                drv = -g_lim;
            end else begin
                ni = m_integ[i] + g_ki * err;
                if (ni > INTEG_MAX) ni = INTEG_MAX;
                if (ni < INTEG_MIN) ni = INTEG_MIN;
                m_integ[i] = ni;
            end
            m_speed[i] = spd;
            r.drv[i] = drv[15:0];
        end
        return r;
    endfunction

    task automatic cfg_write(t_reg r, int unsigned d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            REG_KP:  g_kp = d & 16'hFFFF;
            REG_KD:  g_kd = d & 16'hFFFF;
            REG_KI:  g_ki = d & 16'hFFFF;
            REG_KO:  g_ko = d & 16'hFFFF;
            REG_LIM: g_lim = d & 15'h7FFF;
            default: ;
        endcase
    endtask

    task automatic send_tick(tick_t t, bit typed, bit typed_dv);
        int gap;
        drive_t e;
        gap = (((n_sent / 100) % 4) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.moving        <= t.mov;
        in_if.reset_request <= t.rqr;
        for (int i = 0; i < NM; i++) begin
            in_if.target[i]  <= t.tgt[i];
            in_if.encoder[i] <= t.enc[i];
        end
        do @(posedge i_clk); while (!in_if.ready);
        e = pid_tick(t);
        if (typed) begin
            e.dv = typed_dv;
            for (int i = 0; i < NM; i++) e.drv[i] = '0;
        end
        expected_drives.push_back(e);
        n_sent++;
    endtask

    // all results in, then let the block settle before touching registers
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void add_cfg(t_reg r, int unsigned d);
        row_t w;
        w.is_cfg = 1; w.reg_idx = r; w.data = d; w.typed = 0; w.typed_dv = 0;
        stim_table.push_back(w);
    endfunction

    function automatic void add_tick(bit mv, bit rq, int t0, int t1, int t2, int t3,
                                     int unsigned e0, int unsigned e1, int unsigned e2,
                                     int unsigned e3, bit typed = 0, bit typed_dv = 0);
        row_t w;
        w.is_cfg = 0; w.reg_idx = REG_KP; w.data = 0;
        w.tk.mov = mv; w.tk.rqr = rq;
        w.tk.tgt[0] = t0; w.tk.tgt[1] = t1; w.tk.tgt[2] = t2; w.tk.tgt[3] = t3;
        w.tk.enc[0] = e0; w.tk.enc[1] = e1; w.tk.enc[2] = e2; w.tk.enc[3] = e3;
        w.typed = typed; w.typed_dv = typed_dv;
        stim_table.push_back(w);
    endfunction

    // result side
    initial begin
        int stall;
        drive_t e;
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (n_rx == 50 || n_rx == 800) stall = 400;
            else if (((n_rx / 64) % 4) == 1) stall = 0;
            else stall = $urandom_range(0, 4);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            n_rx++;
            if (expected_drives.size() == 0) begin
                $error("unexpected transaction on output");
                failed = 1;
            end else begin
                e = expected_drives.pop_front();
                if (out_if.drive_valid !== e.dv) begin
                    $error("drive_valid: expected %0d, got %0d", e.dv, out_if.drive_valid);
                    failed = 1;
                end
                for (int i = 0; i < NM; i++) begin
                    if (out_if.drive[i] !== e.drv[i]) begin
                        $error("drive_%0d: expected %0d, got %0d",
                               i, e.drv[i], $signed(out_if.drive[i]));
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        tick_t t;
        int unsigned kp, kd, ki, ko, lim;
        in_if.valid         <= 1'b0;
        in_if.moving        <= 1'b0;
        in_if.reset_request <= 1'b0;
        in_if.target        <= '0;
        in_if.encoder       <= '0;
        g_kp = KP_RST; g_kd = KD_RST; g_ki = KI_RST; g_ko = KO_RST; g_lim = LIM_RST;
        for (int i = 0; i < NM; i++) begin
            m_count[i] = 0; m_speed[i] = 0; m_integ[i] = 0; cur_enc[i] = 0;
        end

        // directed: after reset, extremes, reset request, stop, odd divisor/limit
        add_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        add_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
        add_tick(1, 0, 32767, -32768, 1, -1, 5, -5, 0, 0);
        add_tick(1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        add_tick(1, 1, 100, 100, 100, 100, 10, 20, 30, 40, 1, 0);
        add_tick(1, 0, 10, -10, 10, -10, 15, 15, 35, 35);
        add_tick(0, 0, 10, 10, 10, 10, 99, 99, 99, 99, 1, 0);
        add_tick(0, 0, 10, 10, 10, 10, 7, 7, 7, 7, 1, 0);
        add_tick(1, 0, 5, 5, 5, 5, 100, 200, 300, 400);
        add_cfg(REG_KI, 300);
        add_cfg(REG_LIM, 32767);
        add_cfg(REG_KO, 1);
        add_tick(1, 0, 50, -50, 30, -30, 140, 160, 330, 370);
        add_tick(1, 0, 50, -50, 30, -30, 190, 110, 360, 340);
        add_cfg(REG_KP, 65535);
        add_cfg(REG_KD, 65535);
        add_cfg(REG_KI, 65535);
        add_cfg(REG_KO, 65535);
        add_tick(1, 0, 32767, -32768, 32767, -32768,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 32'h4000_0000);
        add_cfg(REG_KO, 0);
        add_tick(1, 0, -7, 7, 300, -300, 32'h8000_0010, 32'h7FFF_FFF0, 32'hC000_0000, 0);
        add_cfg(REG_LIM, 0);
        add_tick(1, 0, 100, -100, 1, -1, 5, 6, 7, 8, 1, 1);
        add_tick(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                drain();
                cfg_write(stim_table[k].reg_idx, stim_table[k].data);
            end else begin
                send_tick(stim_table[k].tk, stim_table[k].typed, stim_table[k].typed_dv);
            end
        end

        for (int p = 0; p < 8; p++) begin
            drain();
            kp  = (p % 4 == 1) ? 65535 : (p % 4 == 2) ? 0 : $urandom_range(0, 100);
            kd  = (p % 4 == 2) ? 65535 : (p % 4 == 3) ? 0 : $urandom_range(0, 60);
            ki  = (p == 3) ? 65535 : $urandom_range(0, 20);
            ko  = (p == 5) ? 1 : (p == 6) ? 65535 : $urandom_range(1, 200);
            lim = (p == 4) ? 32767 : (p == 7) ? 1 : $urandom_range(1, 2000);
            cfg_write(REG_KP, kp);
            cfg_write(REG_KD, kd);
            cfg_write(REG_KI, ki);
            cfg_write(REG_KO, ko);
            cfg_write(REG_LIM, lim);
            for (int n = 0; n < 200; n++) begin
                t.mov = ($urandom_range(0, 99) < 92);
                t.rqr = ($urandom_range(0, 99) < 4);
                for (int i = 0; i < NM; i++) begin
                    if ($urandom_range(0, 99) < 88)
                        cur_enc[i] = cur_enc[i] + $urandom_range(0, 600) - 300;
                    else
                        cur_enc[i] = $urandom();
                    t.enc[i] = cur_enc[i];
                    if ($urandom_range(0, 99) < 80)
                        t.tgt[i] = $urandom_range(0, 400) - 200;
                    else
                        t.tgt[i] = $urandom();
                end
                send_tick(t, 0, 0);
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (!failed && expected_drives.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
